FILE: design/hcs_pkg.sv
// ----------------------------------------------------------------------------
// hcs_pkg: shared types and constants for the Hamiltonian cycle search
// Command and status groups between the controller and the datapath,
// plus the fixed field widths of the ports.
// ----------------------------------------------------------------------------
package hcs_pkg;

    // Width of the vertex_count register and of the endpoint fields
    localparam int FIELD_W = 7;

    // vertex_count after reset
    localparam logic [FIELD_W-1:0] VERTEX_COUNT_RESET = 7'd64;

    // Controller to datapath
    typedef struct packed {
        logic load_edge;    // input beat accepted, store its edge if in range
        logic init_search;  // start a path at vertex 1
        logic push;         // extend the path with the scanned vertex
        logic advance;      // move the scan to the next vertex
        logic pop;          // drop the top vertex, resume after it
        logic set_top;      // take the new top vertex from the stack read
        logic clear_graph;  // wipe adjacency, degrees, used mask and depth
    } hcs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic deg_ok;       // every vertex in range has degree two or more
        logic depth_full;   // path holds all vertices
        logic depth_one;    // path holds only vertex 1
        logic scan_end;     // scan ran past the last vertex
        logic cand_hit;     // scanned vertex is unused and adjacent to top
        logic close_hit;    // top vertex is adjacent to vertex 1
    } hcs_status_t;

endpackage

FILE: design/hcs_datapath.sv
// ----------------------------------------------------------------------------
// hcs_datapath: graph storage and search datapath
// Holds the adjacency rows, degree bits, path stack, used mask and the
// depth/scan/top registers; acts on controller commands, reports status.
// ----------------------------------------------------------------------------
module hcs_datapath
    import hcs_pkg::*;
#(
    parameter int MAX_VERTICES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [FIELD_W-1:0] cfg_data,
    input  logic               edge_valid,
    input  logic [FIELD_W-1:0] end_a,
    input  logic [FIELD_W-1:0] end_b,
    input  hcs_cmd_t           cmd,
    output hcs_status_t        status
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int XW = (CW > FIELD_W) ? CW : FIELD_W;

    // Configuration
    logic [FIELD_W-1:0] vc_reg;

    // Effective count and endpoints
    logic [XW-1:0] vc_x;
    logic [XW-1:0] n_x;
    logic [XW-1:0] a_x;
    logic [XW-1:0] b_x;
    logic [CW-1:0] n_c;
    logic          edge_ok;
    logic          load;
    logic [VW-1:0] a_idx;
    logic [VW-1:0] b_idx;
    logic [MAX_VERTICES-1:0] onehot_a;
    logic [MAX_VERTICES-1:0] onehot_b;

    // Degree bits: at least one, at least two
    logic [MAX_VERTICES-1:0] deg1_reg;
    logic [MAX_VERTICES-1:0] deg1_next;
    logic [MAX_VERTICES-1:0] deg2_reg;
    logic [MAX_VERTICES-1:0] deg2_next;
    logic [MAX_VERTICES-1:0] low_mask;

    // Adjacency: rows set from end_a side and from end_b side
    logic [MAX_VERTICES-1:0] adj_a_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] adj_b_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] valid_a_reg;
    logic [MAX_VERTICES-1:0] valid_b_reg;
    logic [MAX_VERTICES-1:0] row_a_q;
    logic [MAX_VERTICES-1:0] row_b_q;
    logic                    row_va_q;
    logic                    row_vb_q;
    logic [MAX_VERTICES-1:0] row;

    // Path stack
    logic [VW-1:0] stack_mem [MAX_VERTICES];
    logic [VW-1:0] stack_q;
    logic [VW-1:0] stack_wr_addr;
    logic [VW-1:0] stack_wr_data;
    logic [CW-1:0] depth_m1;

    // Search registers
    logic [CW-1:0]           depth_reg;
    logic [CW-1:0]           depth_next;
    logic [CW-1:0]           scan_reg;
    logic [CW-1:0]           scan_next;
    logic [VW-1:0]           top_reg;
    logic [VW-1:0]           top_next;
    logic [MAX_VERTICES-1:0] used_reg;
    logic [MAX_VERTICES-1:0] used_next;
    logic [VW-1:0]           scan_idx;
    logic [MAX_VERTICES-1:0] onehot_scan;
    logic [MAX_VERTICES-1:0] onehot_top;

    // Hold the vertex count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= VERTEX_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            vc_reg <= cfg_data;
        end
    end

    // Clamp the count to 1..MAX_VERTICES
    assign vc_x = XW'(vc_reg);
    always_comb
    begin
        if (vc_x == '0)
        begin
            n_x = XW'(1);
        end
        else if (vc_x > XW'(MAX_VERTICES))
        begin
            n_x = XW'(MAX_VERTICES);
        end
        else
        begin
            n_x = vc_x;
        end
    end
    assign n_c = CW'(n_x);

    // Qualify the edge of an accepted beat
    assign a_x     = XW'(end_a);
    assign b_x     = XW'(end_b);
    assign edge_ok = edge_valid && (a_x != '0) && (a_x <= n_x)
                     && (b_x != '0) && (b_x <= n_x);
    assign load    = cmd.load_edge && edge_ok;
    assign a_idx   = VW'(a_x - XW'(1));
    assign b_idx   = VW'(b_x - XW'(1));
    assign onehot_a = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << a_idx;
    assign onehot_b = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << b_idx;

    // Bump degrees, saturating at two; a self-loop counts twice
    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            deg1_next[i] = deg1_reg[i] | (load & (onehot_a[i] | onehot_b[i]));
            deg2_next[i] = deg2_reg[i]
                           | (load & ((deg1_reg[i] & (onehot_a[i] | onehot_b[i]))
                                      | (onehot_a[i] & onehot_b[i])));
            low_mask[i]  = (CW'(i) < n_c);
        end
        if (cmd.clear_graph)
        begin
            deg1_next = '0;
            deg2_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg1_reg <= '0;
            deg2_reg <= '0;
        end
        else
        begin
            deg1_reg <= deg1_next;
            deg2_reg <= deg2_next;
        end
    end

    // Track which adjacency rows hold data since the last clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= '0;
            valid_b_reg <= '0;
        end
        else if (cmd.clear_graph)
        begin
            valid_a_reg <= '0;
            valid_b_reg <= '0;
        end
        else if (load)
        begin
            valid_a_reg <= valid_a_reg | onehot_a;
            valid_b_reg <= valid_b_reg | onehot_b;
        end
    end

    // Write adjacency rows, read the row of the top vertex
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (valid_a_reg[a_idx])
            begin
                adj_a_mem[a_idx][b_idx] <= 1'b1;
            end
            else
            begin
                adj_a_mem[a_idx] <= onehot_b;
            end
            if (valid_b_reg[b_idx])
            begin
                adj_b_mem[b_idx][a_idx] <= 1'b1;
            end
            else
            begin
                adj_b_mem[b_idx] <= onehot_a;
            end
        end
        row_a_q  <= adj_a_mem[top_reg];
        row_b_q  <= adj_b_mem[top_reg];
        row_va_q <= valid_a_reg[top_reg];
        row_vb_q <= valid_b_reg[top_reg];
    end

    // Merge both halves; a stale row reads as empty
    assign row = (row_a_q & {MAX_VERTICES{row_va_q}})
                 | (row_b_q & {MAX_VERTICES{row_vb_q}});

    // Path stack: write on init and push, read the entry below the depth
    assign scan_idx      = scan_reg[VW-1:0];
    assign depth_m1      = depth_reg - CW'(1);
    assign stack_wr_addr = cmd.init_search ? '0 : depth_reg[VW-1:0];
    assign stack_wr_data = cmd.init_search ? '0 : scan_idx;

    always_ff @(posedge clk)
    begin
        if (cmd.init_search || cmd.push)
        begin
            stack_mem[stack_wr_addr] <= stack_wr_data;
        end
        stack_q <= stack_mem[depth_m1[VW-1:0]];
    end

    // Advance depth, scan, top and used mask
    assign onehot_scan = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << scan_idx;
    assign onehot_top  = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << top_reg;

    always_comb
    begin
        depth_next = depth_reg;
        scan_next  = scan_reg;
        top_next   = top_reg;
        used_next  = used_reg;
        if (cmd.clear_graph)
        begin
            depth_next = '0;
            used_next  = '0;
        end
        else if (cmd.init_search)
        begin
            depth_next = CW'(1);
            scan_next  = '0;
            top_next   = '0;
            used_next  = {{(MAX_VERTICES-1){1'b0}}, 1'b1};
        end
        else if (cmd.push)
        begin
            depth_next = depth_reg + CW'(1);
            scan_next  = '0;
            top_next   = scan_idx;
            used_next  = used_reg | onehot_scan;
        end
        else if (cmd.pop)
        begin
            depth_next = depth_m1;
            scan_next  = CW'(top_reg) + CW'(1);
            used_next  = used_reg & ~onehot_top;
        end
        else if (cmd.advance)
        begin
            scan_next = scan_reg + CW'(1);
        end
        else if (cmd.set_top)
        begin
            top_next = stack_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            scan_reg  <= '0;
            top_reg   <= '0;
            used_reg  <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
            scan_reg  <= scan_next;
            top_reg   <= top_next;
            used_reg  <= used_next;
        end
    end

    // Report status
    assign status.deg_ok     = &(deg2_reg | ~low_mask);
    assign status.depth_full = (depth_reg == n_c);
    assign status.depth_one  = (depth_reg == CW'(1));
    assign status.scan_end   = (scan_reg == n_c);
    assign status.cand_hit   = !used_reg[scan_idx] && row[scan_idx];
    assign status.close_hit  = row[0];

endmodule

FILE: design/hcs_ctrl.sv
// ----------------------------------------------------------------------------
// hcs_ctrl: load and search controller
// Sequences edge loading, the degree check and the backtracking steps,
// and holds the result beat in an output register.
// ----------------------------------------------------------------------------
module hcs_ctrl
    import hcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        has_cycle,
    output logic        degree_reject,
    input  hcs_status_t status,
    output hcs_cmd_t    cmd
);

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_ROW    = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_CLOSE  = 3'd4;
    localparam logic [2:0] S_POPRD  = 3'd5;
    localparam logic [2:0] S_POPTOP = 3'd6;
    localparam logic [2:0] S_RESULT = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       res_found_reg;
    logic       res_found_next;
    logic       res_reject_reg;
    logic       res_reject_next;
    logic       out_valid_reg;
    logic       has_cycle_reg;
    logic       degree_reject_reg;
    logic       accept;
    logic       slot_free;
    logic       emit;

    assign in_ready  = (state_reg == S_LOAD);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign emit      = (state_reg == S_RESULT) && slot_free;

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        res_found_next  = res_found_reg;
        res_reject_next = res_reject_reg;
        cmd             = '0;
        cmd.load_edge   = accept;
        case (state_reg)
            S_LOAD:
            begin
                if (accept && last)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!status.deg_ok)
                begin
                    res_found_next  = 1'b0;
                    res_reject_next = 1'b1;
                    state_next      = S_RESULT;
                end
                else
                begin
                    cmd.init_search = 1'b1;
                    state_next      = S_ROW;
                end
            end
            S_ROW:
            begin
                state_next = status.depth_full ? S_CLOSE : S_SCAN;
            end
            S_SCAN:
            begin
                if (status.scan_end)
                begin
                    if (status.depth_one)
                    begin
                        res_found_next  = 1'b0;
                        res_reject_next = 1'b0;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        cmd.pop    = 1'b1;
                        state_next = S_POPRD;
                    end
                end
                else if (status.cand_hit)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_ROW;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            S_CLOSE:
            begin
                if (status.close_hit)
                begin
                    res_found_next  = 1'b1;
                    res_reject_next = 1'b0;
                    state_next      = S_RESULT;
                end
                else if (status.depth_one)
                begin
                    res_found_next  = 1'b0;
                    res_reject_next = 1'b0;
                    state_next      = S_RESULT;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_POPRD;
                end
            end
            S_POPRD:
            begin
                state_next = S_POPTOP;
            end
            S_POPTOP:
            begin
                cmd.set_top = 1'b1;
                state_next  = S_ROW;
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    cmd.clear_graph = 1'b1;
                    state_next      = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Hold state and the output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the decision and the output payload
    always_ff @(posedge clk)
    begin
        res_found_reg  <= res_found_next;
        res_reject_reg <= res_reject_next;
        if (emit)
        begin
            has_cycle_reg     <= res_found_reg;
            degree_reject_reg <= res_reject_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign has_cycle     = has_cycle_reg;
    assign degree_reject = degree_reject_reg;

endmodule

FILE: design/hamiltonian_cycle_search.sv
// ----------------------------------------------------------------------------
// hamiltonian_cycle_search: Hamiltonian cycle search by backtracking
// Loads an undirected graph one edge per beat, then searches for a cycle
// through all vertices and returns one result beat per graph.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries edge_valid, end_a, end_b and
//   last. Edge beats are taken one per cycle while the block is loading.
//   The beat with last set closes the graph; intake then stays closed until
//   the result has been moved into the output register.
//   Output channel (out_valid/out_ready) carries has_cycle and
//   degree_reject, one beat per graph.
//   After the last beat come the degree check and a read of the row of
//   vertex 1, then the search: each scanned vertex is checked in the scan
//   state, each push adds a row read, each backtrack a stack read and a row
//   read, and the result passes through the result state into the output
//   register. A degree reject goes from the check state to the result state.
//   The search steps through one vertex per cycle against the adjacency
//   row of the path top, read from a registered row memory.
//   A stalled receiver holds the result beat in the output register; the
//   next graph loads meanwhile, and a finished search waits for the slot.
//   Reset empties the graph (row valid, degree bits) at once; vertex_count
//   resets to 64. cfg_write loads it; user rule: only while idle, unchecked.
// ----------------------------------------------------------------------------
module hamiltonian_cycle_search
    import hcs_pkg::*;
#(
    parameter int MAX_VERTICES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [FIELD_W-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               edge_valid,
    input  logic [FIELD_W-1:0] end_a,
    input  logic [FIELD_W-1:0] end_b,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               has_cycle,
    output logic               degree_reject
);

    hcs_cmd_t    cmd;
    hcs_status_t status;

    // Sequence loading and search
    hcs_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .last          (last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .has_cycle     (has_cycle),
        .degree_reject (degree_reject),
        .status        (status),
        .cmd           (cmd)
    );

    // Store the graph and run the search steps
    hcs_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .edge_valid (edge_valid),
        .end_a      (end_a),
        .end_b      (end_b),
        .cmd        (cmd),
        .status     (status)
    );

endmodule
